@@ src/mutex_with_fifo_wait_queue_defines.svh @@
// Assertion macros for the mutex with FIFO wait queue.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MUTEX_WITH_FIFO_WAIT_QUEUE_DEFINES_SVH
`define MUTEX_WITH_FIFO_WAIT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MWQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mwq_pkg.sv @@
// Package for the mutex with FIFO wait queue: sizes, codes and the
// transfer and control types. No dependencies.
`default_nettype none

package mwq_pkg;

    localparam int MAX_WAITERS    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int ID_W           = 8;
    localparam int OP_W           = 3;
    localparam int STAT_W         = 3;
    localparam int COUNT_W        = 6;
    localparam int CNT_W          = $clog2(MAX_WAITERS + 1);
    localparam int SUM_W          = ((COUNT_W > CNT_W) ? COUNT_W : CNT_W) + 2;

    localparam logic [OP_W-1:0] OP_LOCK       = 3'd0;
    localparam logic [OP_W-1:0] OP_TRYLOCK    = 3'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK     = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL     = 3'd3;
    localparam logic [OP_W-1:0] OP_CANCEL_ALL = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_QUEUED      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BUSY        = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_OWNER   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_WAITING = 3'd4;
    localparam logic [STAT_W-1:0] STAT_QUEUE_FULL  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [ID_W-1:0] thread_id;
    } mwq_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   woken_thread;
        logic [ID_W-1:0]   owner_now;
        logic              last;
    } mwq_rsp_t;

    typedef struct packed {
        logic            enq;
        logic            search;
        logic            shift;
        logic            shift_all;
        logic [ID_W-1:0] tid;
    } mwq_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } mwq_state_t;

endpackage

`default_nettype wire

@@ src/mwq_cell.sv @@
// One wait queue slot: holds a thread id, matches it, takes its neighbor's id.
// Depends on mwq_pkg.
`default_nettype none

module mwq_cell
    import mwq_pkg::*;
(
    input  wire logic            clk,
    input  wire mwq_ctl_t        ctl,
    input  wire logic            valid,
    input  wire logic            write_en,
    input  wire logic            hit_in,
    input  wire logic [ID_W-1:0] next_id,
    output logic      [ID_W-1:0] id,
    output logic                 hit_out
);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            match;

    assign match   = ctl.search & valid & (id_reg == ctl.tid);
    assign hit_out = hit_in | match;
    assign id      = id_reg;

    always_comb
    begin
        id_next = id_reg;
        if (write_en)
        begin
            id_next = ctl.tid;
        end
        else if (ctl.shift && hit_out)
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

`default_nettype wire

@@ src/mwq_chain.sv @@
// Row of wait queue cells, oldest waiter at the head.
// Depends on mwq_pkg and mwq_cell.
`default_nettype none

module mwq_chain
    import mwq_pkg::*;
(
    input  wire logic             clk,
    input  wire mwq_ctl_t         ctl,
    input  wire logic [CNT_W-1:0] total,
    output logic      [ID_W-1:0]  head,
    output logic                  found
);

    logic [ID_W-1:0]      ids [MAX_WAITERS];
    logic [MAX_WAITERS:0] hit;

    assign hit[0] = ctl.shift_all;
    assign head   = ids[0];
    assign found  = hit[MAX_WAITERS];

    for (genvar i = 0; i < MAX_WAITERS; i++)
    begin : g_cell
        logic [ID_W-1:0] nxt;
        logic            slot_valid;
        logic            slot_write;

        if (i == MAX_WAITERS - 1)
        begin : g_tail
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = ids[i+1];
        end

        assign slot_valid = (total > CNT_W'(i));
        assign slot_write = ctl.enq && (total == CNT_W'(i));

        mwq_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .valid    (slot_valid),
            .write_en (slot_write),
            .hit_in   (hit[i]),
            .next_id  (nxt),
            .id       (ids[i]),
            .hit_out  (hit[i+1])
        );
    end

endmodule

`default_nettype wire

@@ src/mutex_with_fifo_wait_queue.sv @@
// Mutex with FIFO wait queue: top level with control sequencer and result register.
// An item is accepted from idle and executed in the execute state, which registers its
// result once the output is free; no new item is accepted until the state is idle again.
// Cancel-all with waiters drains the queue, one result per waiter, set by the queue head.
// Reset frees the mutex (count one, no owner) and empties the queue; cells hold stale ids.
// Depends on mwq_pkg, mwq_chain and mutex_with_fifo_wait_queue_defines.svh.
`default_nettype none
`include "mutex_with_fifo_wait_queue_defines.svh"

module mutex_with_fifo_wait_queue
    import mwq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire mwq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output mwq_rsp_t      rsp
);

    localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << THREAD_ID_BITS) - 1);
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic signed [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    function automatic logic signed [COUNT_W-1:0] count_add(
        input logic signed [COUNT_W-1:0] cur,
        input logic        [CNT_W-1:0]   amt
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim;
        sum = $signed({{(SUM_W-COUNT_W){cur[COUNT_W-1]}}, cur})
            + $signed({{(SUM_W-CNT_W){1'b0}}, amt});
        lim = $signed({{(SUM_W-COUNT_W){1'b0}}, COUNT_MAX});
        if (sum > lim)
        begin
            return COUNT_MAX;
        end
        return sum[COUNT_W-1:0];
    endfunction

    mwq_state_t                 state_reg, state_next;
    logic [OP_W-1:0]            op_reg, op_next;
    logic [ID_W-1:0]            tid_reg, tid_next;
    logic signed [COUNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]            owner_reg, owner_next;
    logic [CNT_W-1:0]           total_reg, total_next;
    logic [CNT_W-1:0]           remain_reg, remain_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    mwq_rsp_t                   rsp_reg, rsp_next;

    mwq_ctl_t                   ctl;
    logic [ID_W-1:0]            head;
    logic                       found;
    logic                       out_free;
    logic signed [COUNT_W-1:0]  inc_one;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign inc_one   = count_add(count_reg, CNT_W'(1));

    mwq_chain u_chain (
        .clk   (clk),
        .ctl   (ctl),
        .total (total_reg),
        .head  (head),
        .found (found)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        count_next     = count_reg;
        owner_next     = owner_reg;
        total_next     = total_reg;
        remain_next    = remain_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ctl            = '0;
        ctl.tid        = tid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    tid_next   = req.thread_id & ID_MASK;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    rsp_next.status       = STAT_OK;
                    rsp_next.woken_thread = '0;
                    rsp_next.last         = 1'b1;
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                    case (op_reg)
                        OP_LOCK:
                        begin
                            if (count_reg == COUNT_ONE)
                            begin
                                count_next = '0;
                                owner_next = tid_reg;
                            end
                            else if (tid_reg == '0)
                            begin
                                rsp_next.status = STAT_BUSY;
                            end
                            else if (total_reg == CNT_W'(MAX_WAITERS))
                            begin
                                rsp_next.status = STAT_QUEUE_FULL;
                            end
                            else
                            begin
                                if (count_reg > COUNT_MIN)
                                begin
                                    count_next = count_reg - COUNT_ONE;
                                end
                                ctl.enq         = 1'b1;
                                total_next      = total_reg + CNT_W'(1);
                                rsp_next.status = STAT_QUEUED;
                            end
                        end
                        OP_TRYLOCK:
                        begin
                            if (count_reg == COUNT_ONE)
                            begin
                                count_next = '0;
                                owner_next = tid_reg;
                            end
                            else
                            begin
                                rsp_next.status = STAT_BUSY;
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (owner_reg != tid_reg)
                            begin
                                rsp_next.status = STAT_NOT_OWNER;
                            end
                            else if (total_reg == '0)
                            begin
                                owner_next = '0;
                                count_next = inc_one[COUNT_W-1] ? COUNT_ONE : inc_one;
                            end
                            else
                            begin
                                ctl.shift             = 1'b1;
                                ctl.shift_all         = 1'b1;
                                rsp_next.woken_thread = head;
                                owner_next            = head;
                                total_next            = total_reg - CNT_W'(1);
                                count_next            = inc_one;
                            end
                        end
                        OP_CANCEL:
                        begin
                            ctl.search = 1'b1;
                            ctl.shift  = 1'b1;
                            if (found)
                            begin
                                total_next = total_reg - CNT_W'(1);
                                count_next = inc_one;
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOT_WAITING;
                            end
                        end
                        OP_CANCEL_ALL:
                        begin
                            if (total_reg != '0)
                            begin
                                count_next     = count_add(count_reg, total_reg);
                                remain_next    = total_reg;
                                total_next     = '0;
                                rsp_valid_next = rsp_valid_reg && rsp_stall;
                                rsp_next       = rsp_reg;
                                state_next     = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.owner_now = (state_next == ST_DRAIN) ? rsp_reg.owner_now
                                                                  : owner_next;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    ctl.shift             = 1'b1;
                    ctl.shift_all         = 1'b1;
                    rsp_next.status       = STAT_OK;
                    rsp_next.woken_thread = head;
                    rsp_next.owner_now    = owner_reg;
                    rsp_next.last         = (remain_reg == CNT_W'(1));
                    rsp_valid_next        = 1'b1;
                    remain_next           = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_ONE;
            owner_reg     <= '0;
            total_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            owner_reg     <= owner_next;
            total_reg     <= total_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        tid_reg <= tid_next;
        rsp_reg <= rsp_next;
    end

    `MWQ_ASSERT_NOW(a_total_bound, 1'b1, total_reg <= CNT_W'(MAX_WAITERS), "queue length past capacity")
    `MWQ_ASSERT_NOW(a_drain_empty, state_reg == ST_DRAIN, total_reg == '0 && remain_reg != '0, "drain with queue not cleared")
    `MWQ_ASSERT_NEXT(a_drain_out, state_reg == ST_DRAIN && out_free, rsp_valid_reg, "drain step without result")

endmodule

`default_nettype wire
